>>> rtl/cwgm_pkg.sv
// ----------------------------------------------------------------------------
// cwgm_pkg: shared types and constants for the codon weight geometric mean
// Opcodes, base characters, controller state, command/status structs and
// the elaboration-time square-root chain for the exp2 factors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cwgm_pkg;

  localparam int LOG_W             = 24;  // signed Q8.16 log weight
  localparam int RATE_W            = 32;  // unsigned Q16.16 result
  localparam int COUNT_BITS_DEF    = 20;
  localparam int LOG_FRAC_BITS_DEF = 16;
  localparam int Q30_W             = 32;  // exp2 accumulator, Q2.30
  localparam int TABLE_DEPTH       = 64;
  localparam int ADDR_W            = 6;

  // Opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CODON = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Base characters
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_DIV,
    ST_EXP_MUL,
    ST_EXP_RND,
    ST_SCALE
  } state_t;

  typedef struct packed {
    logic accept;       // input transaction taken this cycle
    logic clear_empty;  // end of an empty transcript
    logic div_start;    // load divider, reset exp2 accumulator
    logic div_step;     // one quotient bit
    logic exp_mul;      // multiply accumulator by factor
    logic exp_rnd;      // round and update accumulator
    logic finish;       // write result register, clear sums
  } cmd_t;

  typedef struct packed {
    logic tally_zero;
    logic div_last;
    logic exp_last;
    logic out_free;
  } status_t;

  // {valid, 2-bit code}
  function automatic logic [2:0] base_code(input logic [7:0] b);
    logic [2:0] r;
    case (b)
      CHAR_A:  r = 3'b100;
      CHAR_C:  r = 3'b101;
      CHAR_G:  r = 3'b110;
      CHAR_T:  r = 3'b111;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  // Floor integer square root, used at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q2.30 from k repeated square roots of 2.0
  function automatic logic [Q30_W-1:0] exp2_factor(input int k);
    logic [63:0] f;
    f = 64'd2 << 30;
    for (int i = 0; i < k; i++) begin
      f = isqrt64(f << 30);
    end
    return f[Q30_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/cwgm_ctrl.sv
// ----------------------------------------------------------------------------
// cwgm_ctrl: sequencing controller
// Takes transactions in idle, then runs settle, divide, exp2 and scale
// steps for an end-of-transcript item; an empty one returns from settle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwgm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire logic [1:0]       opcode,
  output logic                  item_stall,
  output cwgm_pkg::cmd_t        cmd,
  input  wire cwgm_pkg::status_t status
);
  import cwgm_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.accept = item_valid;
        if (item_valid && opcode == OP_END) state_next = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (status.tally_zero) begin
          cmd.clear_empty = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_EXP_MUL;
      end
      ST_EXP_MUL: begin
        cmd.exp_mul = 1'b1;
        state_next  = ST_EXP_RND;
      end
      ST_EXP_RND: begin
        cmd.exp_rnd = 1'b1;
        state_next  = status.exp_last ? ST_SCALE : ST_EXP_MUL;
      end
      ST_SCALE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/cwgm_datapath.sv
// ----------------------------------------------------------------------------
// cwgm_datapath: weight table, accumulator, divider, exp2 unit, result reg
// Codons are accumulated one stage after acceptance; the mean is formed by
// a restoring divider and a shift-and-multiply exp2 over the fraction bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwgm_datapath #(
  parameter int COUNT_BITS    = cwgm_pkg::COUNT_BITS_DEF,
  parameter int LOG_FRAC_BITS = cwgm_pkg::LOG_FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire cwgm_pkg::cmd_t                     cmd,
  output cwgm_pkg::status_t                       status,
  input  wire logic [1:0]                         opcode,
  input  wire logic [7:0]                         base_first,
  input  wire logic [7:0]                         base_second,
  input  wire logic [7:0]                         base_third,
  input  wire logic signed [cwgm_pkg::LOG_W-1:0]  log_weight,
  output logic [cwgm_pkg::RATE_W-1:0]             mean_rate,
  output logic [COUNT_BITS-1:0]                   codons_used,
  output logic                                    overflowed,
  output logic                                    result_valid,
  input  wire logic                               result_stall
);
  import cwgm_pkg::*;

  localparam int SUM_W  = LOG_W + COUNT_BITS;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int KCNT_W = $clog2(LOG_FRAC_BITS);
  localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

  // Base decode
  logic [2:0] code1, code2, code3;
  logic       bases_ok;
  logic [ADDR_W-1:0] addr;

  assign code1    = base_code(base_first);
  assign code2    = base_code(base_second);
  assign code3    = base_code(base_third);
  assign bases_ok = code1[2] & code2[2] & code3[2];
  assign addr     = {code1[1:0], code2[1:0], code3[1:0]};

  // Weight table and valid bits
  logic signed [LOG_W-1:0] weight_mem [TABLE_DEPTH];
  logic signed [LOG_W-1:0] rd_data;
  logic [TABLE_DEPTH-1:0]  present;
  logic                    pend;

  always_ff @(posedge clk) begin
    if (cmd.accept && opcode == OP_LOAD && bases_ok) begin
      weight_mem[addr] <= log_weight;
    end
    rd_data <= weight_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      pend    <= 1'b0;
    end else begin
      if (cmd.accept && opcode == OP_LOAD && bases_ok) present[addr] <= 1'b1;
      pend <= cmd.accept && opcode == OP_CODON && bases_ok && present[addr];
    end
  end

  // Running sum and count
  logic signed [SUM_W-1:0] log_total;
  logic [COUNT_BITS-1:0]   codon_tally;
  logic                    tally_saturated;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_empty || cmd.finish) begin
      log_total       <= '0;
      codon_tally     <= '0;
      tally_saturated <= 1'b0;
    end else if (pend) begin
      if (codon_tally == TALLY_MAX) begin
        tally_saturated <= 1'b1;
      end else begin
        log_total   <= log_total + {{COUNT_BITS{rd_data[LOG_W-1]}}, rd_data};
        codon_tally <= codon_tally + 1'b1;
        if (codon_tally == TALLY_MAX - 1'b1) tally_saturated <= 1'b1;
      end
    end
  end

  // Restoring divider on the magnitude, one bit a cycle
  logic [SUM_W-1:0]      div_num;
  logic [COUNT_BITS-1:0] div_rem;
  logic                  div_neg;
  logic [DCNT_W-1:0]     div_cnt;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  rem_ge;

  assign rem_sh = {div_rem, div_num[SUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, codon_tally};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num <= log_total[SUM_W-1] ? SUM_W'(-log_total) : SUM_W'(log_total);
      div_neg <= log_total[SUM_W-1];
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= rem_ge ? COUNT_BITS'(rem_sh - {1'b0, codon_tally})
                        : rem_sh[COUNT_BITS-1:0];
      div_num <= {div_num[SUM_W-2:0], rem_ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Floor quotient, then integer and fraction parts
  logic [LOG_W-1:0]         qmag;
  logic signed [LOG_W-1:0]  mean_q;
  logic signed [LOG_W-1:0]  ip;
  logic [LOG_FRAC_BITS-1:0] frac;

  assign qmag   = div_num[LOG_W-1:0];
  assign mean_q = !div_neg ? qmag : ((div_rem != '0) ? ~qmag : -qmag);
  assign ip     = mean_q >>> LOG_FRAC_BITS;
  assign frac   = mean_q[LOG_FRAC_BITS-1:0];

  // exp2 factor table
  logic [Q30_W-1:0] fac_rom [LOG_FRAC_BITS];
  for (genvar g = 0; g < LOG_FRAC_BITS; g++) begin : g_fac
    assign fac_rom[g] = exp2_factor(g + 1);
  end

  // exp2 of the fraction, Q2.30
  logic [Q30_W-1:0]   acc;
  logic [2*Q30_W-1:0] prod;
  logic [2*Q30_W-1:0] prod_rnd;
  logic [KCNT_W-1:0]  kidx;
  logic               frac_bit;

  assign prod_rnd = prod + (64'd1 << 29);
  assign frac_bit = frac[KCNT_W'(LOG_FRAC_BITS - 1) - kidx];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      acc  <= Q30_W'(64'd1 << 30);
      kidx <= '0;
    end else if (cmd.exp_mul) begin
      prod <= acc * fac_rom[kidx];
    end else if (cmd.exp_rnd) begin
      if (frac_bit) acc <= prod_rnd[61:30];
      kidx <= kidx + 1'b1;
    end
  end

  // Scale by 2^ip to Q16.16 with round half up and saturation
  logic signed [LOG_W-1:0] sh_full;
  logic [5:0]              sh;
  logic [40:0]             rnd_sum;
  logic [32:0]             val;
  logic                    sat_s;
  logic [RATE_W-1:0]       rate;

  always_comb begin
    sh_full = LOG_W'(14) - ip;
    sh      = sh_full[5:0];
    rnd_sum = {9'd0, acc} + (41'd1 << (sh - 6'd1));
    val     = '0;
    sat_s   = 1'b0;
    if (ip >= 16) begin
      sat_s = 1'b1;
    end else if (ip >= 14) begin
      val = (ip == 15) ? {acc, 1'b0} : {1'b0, acc};
    end else if (sh_full < 40) begin
      val = 33'(rnd_sum >> sh);
    end
    if (val[32]) sat_s = 1'b1;
    rate = sat_s ? '1 : val[RATE_W-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      mean_rate   <= rate;
      codons_used <= codon_tally;
      overflowed  <= sat_s | tally_saturated;
    end
  end

  // Status back to the controller
  assign status.tally_zero = codon_tally == '0;
  assign status.div_last   = div_cnt == DCNT_W'(SUM_W - 1);
  assign status.exp_last   = kidx == KCNT_W'(LOG_FRAC_BITS - 1);
  assign status.out_free   = !result_valid || !result_stall;

endmodule

`default_nettype wire

>>> rtl/codon_weight_geometric_mean.sv
// ----------------------------------------------------------------------------
// codon_weight_geometric_mean: geometric mean of per-codon rates
// Usage:
//   Input channel (item_valid / item_stall) carries opcode, three ASCII
//   bases and a Q8.16 log weight. Load writes a table entry, codon adds a
//   present entry's weight to the running sum, end emits 2^(sum/count).
//   Loads, codons and ignored items are taken back to back while idle;
//   a codon's weight is added in the cycle after its transaction.
//   An end item holds item_stall through a settle step, COUNT_BITS + 24
//   divider steps, a multiply and a round step per fraction bit on the
//   shared multiplier, then scaling. An empty transcript ends at settle.
//   Output channel (result_valid / result_stall) holds mean_rate (Q16.16),
//   codons_used and overflowed in a register; while the receiver stalls,
//   the block keeps taking loads and codons, and a following end item
//   waits in its last step until the register is free.
//   Reset clears the table valid bits, sums, count and result_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module codon_weight_geometric_mean #(
  parameter int COUNT_BITS    = cwgm_pkg::COUNT_BITS_DEF,
  parameter int LOG_FRAC_BITS = cwgm_pkg::LOG_FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire logic [1:0]                         opcode,
  input  wire logic [7:0]                         base_first,
  input  wire logic [7:0]                         base_second,
  input  wire logic [7:0]                         base_third,
  input  wire logic signed [cwgm_pkg::LOG_W-1:0]  log_weight,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic [cwgm_pkg::RATE_W-1:0]             mean_rate,
  output logic [COUNT_BITS-1:0]                   codons_used,
  output logic                                    overflowed
);
  import cwgm_pkg::*;

  cmd_t    cmd;
  status_t status;

  cwgm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .opcode     (opcode),
    .item_stall (item_stall),
    .cmd        (cmd),
    .status     (status)
  );

  cwgm_datapath #(
    .COUNT_BITS    (COUNT_BITS),
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .opcode       (opcode),
    .base_first   (base_first),
    .base_second  (base_second),
    .base_third   (base_third),
    .log_weight   (log_weight),
    .mean_rate    (mean_rate),
    .codons_used  (codons_used),
    .overflowed   (overflowed),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

`ifndef ASSERT_OFF
  // A result always reports at least one codon
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> codons_used != '0)
    else $error("result with zero codon count");

  // An accepted end item blocks the input on the next cycle
  a_end_stalls: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && opcode == OP_END |=> item_stall)
    else $error("input not stalled after end item");
`endif

endmodule

`default_nettype wire
